[rtl/sit_pkg.sv]
package sit_pkg;

	localparam int CAPACITY   = 64;
	localparam int COORD_BITS = 32;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int ID_BITS    = 14;

	localparam logic [ID_BITS-1:0] MIN_ID_RESET = ID_BITS'(9500);

	localparam logic [2:0] ACT_LOW_ID   = 3'd0;
	localparam logic [2:0] ACT_LOST     = 3'd1;
	localparam logic [2:0] ACT_INSERTED = 3'd2;
	localparam logic [2:0] ACT_REPLACED = 3'd3;
	localparam logic [2:0] ACT_FULL     = 3'd4;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [31:0]        ref_start;
		logic [31:0]        ref_stop;
		logic [ID_BITS-1:0] identity;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  removed_count;
		logic [6:0]  entry_count;
		logic [31:0] covered_total;
	} out_item_t;

	// memory read address source
	typedef enum logic [1:0] {
		RD_I   = 2'd0,
		RD_J   = 2'd1,
		RD_PM1 = 2'd2,
		RD_P   = 2'd3
	} rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;       // capture match, clear scan index
		logic    cfg_wr;     // take new threshold
		logic    rd;         // issue memory read
		rd_sel_t rd_sel;
		logic    adv_i;      // step first-overlap index
		logic    start_run;  // j = i+1, run = len(i)
		logic    adv_j;      // add entry j to run, step j
		logic    ins_begin;  // p = count
		logic    ins_shift;  // write entry p-1 to p, step p down
		logic    rep_begin;  // p = j
		logic    rm_shift;   // write entry p to p-(j-i-1), step p up
		logic    wr_new;     // write match at index i
		logic    commit_ins;
		logic    commit_rep;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic low_id;
		logic i_end;      // i == count
		logic hi_le_mn;   // entry read at i ends at or before mn
		logic overlap_i;  // mx > low(i)
		logic j_end;      // j == count
		logic lo_lt_mx;   // entry read at j starts before mx
		logic full;
		logic run_gt;     // run > len
		logic p_at_i;
		logic p_at_cnt;
	} dp_sts_t;

endpackage

[rtl/sit_datapath.sv]
module sit_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sit_pkg::dp_cmd_t              cmd,
	output sit_pkg::dp_sts_t              sts,
	input  sit_pkg::in_item_t             item,
	input  logic [sit_pkg::ID_BITS-1:0]   cfg_data,
	output logic [6:0]                    removed,
	output logic [6:0]                    entries,
	output logic [31:0]                   total
);
	localparam int IB = sit_pkg::IDX_BITS;
	localparam int CB = sit_pkg::CNT_BITS;
	localparam int W  = sit_pkg::COORD_BITS;

	logic [2*W-1:0] mem_q [sit_pkg::CAPACITY];
	logic [2*W-1:0] rd_q;

	sit_pkg::coord_t a, b, mn_q, mx_q, len_q, run_q, tot_q, rd_lo, rd_hi;
	logic [sit_pkg::ID_BITS-1:0] id_q, min_id_q;
	logic [CB-1:0]  i_q, j_q, p_q, cnt_q, removed_q;
	logic [CB-1:0]  p_m1, rm_dst;

	logic [IB-1:0]  rd_addr, wr_addr;
	logic           wr_en;
	logic [2*W-1:0] wr_data;

	assign a      = W'(item.ref_start);
	assign b      = W'(item.ref_stop);
	assign rd_lo  = rd_q[2*W-1:W];
	assign rd_hi  = rd_q[W-1:0];
	assign p_m1   = p_q - CB'(1);
	// closing the gap moves entry p down over the j-i-1 spare slots
	assign rm_dst = p_q - j_q + i_q + CB'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			sit_pkg::RD_I:   rd_addr = i_q[IB-1:0];
			sit_pkg::RD_J:   rd_addr = j_q[IB-1:0];
			sit_pkg::RD_PM1: rd_addr = p_m1[IB-1:0];
			sit_pkg::RD_P:   rd_addr = p_q[IB-1:0];
		endcase
	end

	always_comb begin
		wr_en   = cmd.wr_new | cmd.ins_shift | cmd.rm_shift;
		wr_addr = p_q[IB-1:0];
		wr_data = rd_q;
		if (cmd.wr_new) begin
			wr_addr = i_q[IB-1:0];
			wr_data = {mn_q, mx_q};
		end else if (cmd.rm_shift) begin
			wr_addr = rm_dst[IB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= mem_q[rd_addr];
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mn_q  <= (a < b) ? a : b;
			mx_q  <= (a < b) ? b : a;
			len_q <= (a < b) ? b - a : a - b;
			id_q  <= item.identity;
		end
		if (cmd.load) i_q <= '0;
		else if (cmd.adv_i) i_q <= i_q + CB'(1);
		if (cmd.start_run) begin
			j_q   <= i_q + CB'(1);
			run_q <= rd_hi - rd_lo;
		end else if (cmd.adv_j) begin
			j_q   <= j_q + CB'(1);
			run_q <= run_q + (rd_hi - rd_lo);
		end
		if (cmd.ins_begin) p_q <= cnt_q;
		else if (cmd.rep_begin) p_q <= j_q;
		else if (cmd.ins_shift) p_q <= p_m1;
		else if (cmd.rm_shift) p_q <= p_q + CB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_id_q  <= sit_pkg::MIN_ID_RESET;
			cnt_q     <= '0;
			tot_q     <= '0;
			removed_q <= '0;
		end else begin
			if (cmd.cfg_wr) min_id_q <= cfg_data;
			if (cmd.load) removed_q <= '0;
			else if (cmd.commit_rep) removed_q <= j_q - i_q;
			if (cmd.commit_ins) begin
				cnt_q <= cnt_q + CB'(1);
				tot_q <= tot_q + len_q;
			end else if (cmd.commit_rep) begin
				cnt_q <= cnt_q - (j_q - i_q) + CB'(1);
				tot_q <= tot_q - run_q + len_q;
			end
		end
	end

	always_comb begin
		sts.low_id    = id_q < min_id_q;
		sts.i_end     = i_q == cnt_q;
		sts.hi_le_mn  = rd_hi <= mn_q;
		sts.overlap_i = mx_q > rd_lo;
		sts.j_end     = j_q == cnt_q;
		sts.lo_lt_mx  = rd_lo < mx_q;
		sts.full      = cnt_q == CB'(sit_pkg::CAPACITY);
		sts.run_gt    = run_q > len_q;
		sts.p_at_i    = p_q == i_q;
		sts.p_at_cnt  = p_q == cnt_q;
	end

	assign removed = 7'(removed_q);
	assign entries = 7'(cnt_q);
	assign total   = 32'(tot_q);
endmodule

[rtl/sorted_interval_table_insert.sv]
// channel | valid / ready         | beat
// in      | in_valid / in_ready   | sit_pkg::in_item_t: ref_start, ref_stop, identity
// out     | out_valid / out_ready | sit_pkg::out_item_t: action, removed_count, entry_count,
//         |                       | covered_total
// cfg     | cfg_valid / cfg_ready | cfg_data: min_identity
// For every table entry the walk touches, a registered read is followed by a compare or a
// write. Reset clears count and total and sets min_identity to 9500; the memory is not
// cleared, as only entries below the count are read. in and cfg are taken only when
// idle, so a held result stalls both until out_ready.
module sorted_interval_table_insert (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sit_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sit_pkg::out_item_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sit_pkg::ID_BITS-1:0] cfg_data
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_CHK  = 10'b0000000010,
		S_SCAN = 10'b0000000100,
		S_RCHK = 10'b0000001000,
		S_RUN  = 10'b0000010000,
		S_INSC = 10'b0000100000,
		S_INSW = 10'b0001000000,
		S_RMC  = 10'b0010000000,
		S_RMW  = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	logic [2:0]       act_q, act_d;
	sit_pkg::dp_cmd_t cmd;
	sit_pkg::dp_sts_t sts;
	logic [6:0]       removed, entries;
	logic [31:0]      total;

	sit_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.item(in_data), .cfg_data(cfg_data),
		.removed(removed), .entries(entries), .total(total)
	);

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_data.action        = act_q;
	assign out_data.removed_count = removed;
	assign out_data.entry_count   = entries;
	assign out_data.covered_total = total;

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = sit_pkg::RD_I;
		state_d    = state_q;
		act_d      = act_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.cfg_wr = cfg_valid;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.low_id) begin
					act_d = sit_pkg::ACT_LOW_ID; state_d = S_OUT;
				end else if (sts.i_end) begin
					if (sts.full) begin
						act_d = sit_pkg::ACT_FULL; state_d = S_OUT;
					end else begin
						cmd.ins_begin = 1'b1; state_d = S_INSC;
					end
				end else begin
					cmd.rd = 1'b1; cmd.rd_sel = sit_pkg::RD_I; state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hi_le_mn) begin
					cmd.adv_i = 1'b1; state_d = S_CHK;
				end else if (!sts.overlap_i) begin
					if (sts.full) begin
						act_d = sit_pkg::ACT_FULL; state_d = S_OUT;
					end else begin
						cmd.ins_begin = 1'b1; state_d = S_INSC;
					end
				end else begin
					cmd.start_run = 1'b1; state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				if (!sts.j_end) begin
					cmd.rd = 1'b1; cmd.rd_sel = sit_pkg::RD_J; state_d = S_RUN;
				end else if (sts.run_gt) begin
					act_d = sit_pkg::ACT_LOST; state_d = S_OUT;
				end else begin
					cmd.wr_new = 1'b1; cmd.rep_begin = 1'b1; state_d = S_RMC;
				end
			end
			S_RUN: begin
				if (sts.lo_lt_mx) begin
					cmd.adv_j = 1'b1; state_d = S_RCHK;
				end else if (sts.run_gt) begin
					act_d = sit_pkg::ACT_LOST; state_d = S_OUT;
				end else begin
					cmd.wr_new = 1'b1; cmd.rep_begin = 1'b1; state_d = S_RMC;
				end
			end
			S_INSC: begin
				// shift from the top down, then drop the match into the hole
				if (sts.p_at_i) begin
					cmd.wr_new = 1'b1; cmd.commit_ins = 1'b1;
					act_d = sit_pkg::ACT_INSERTED; state_d = S_OUT;
				end else begin
					cmd.rd = 1'b1; cmd.rd_sel = sit_pkg::RD_PM1; state_d = S_INSW;
				end
			end
			S_INSW: begin
				cmd.ins_shift = 1'b1; state_d = S_INSC;
			end
			S_RMC: begin
				if (sts.p_at_cnt) begin
					cmd.commit_rep = 1'b1;
					act_d = sit_pkg::ACT_REPLACED; state_d = S_OUT;
				end else begin
					cmd.rd = 1'b1; cmd.rd_sel = sit_pkg::RD_P; state_d = S_RMW;
				end
			end
			S_RMW: begin
				cmd.rm_shift = 1'b1; state_d = S_RMC;
			end
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= sit_pkg::ACT_LOW_ID;
		end else begin
			state_q <= state_d;
			act_q   <= act_d;
		end
	end
endmodule
